/* hw/rtl/hue_whiteness_value_to_rgb_assert.svh */
// Assertion macros for the color conversion RTL, used by the top level.
`ifndef HUE_WHITENESS_VALUE_TO_RGB_ASSERT_SVH
`define HUE_WHITENESS_VALUE_TO_RGB_ASSERT_SVH
`ifndef SYNTHESIS
`define HWV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define HWV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define HWV_ASSERT(lbl, clk, rst, prop)
`define HWV_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/hwv_pkg.sv */
// Shared types, constants and channel arrangement for the color conversion block.
package hwv_pkg;

   localparam int MID_DEPTH   = 4;
   localparam int OUT_DEPTH   = 8;
   localparam int BACK_STAGES = 3;
   localparam int WHITE_W     = 17;
   localparam int BRIGHT_W    = 17;
   localparam logic [7:0] CHAN_FULL = 8'd255;

   // Members name the channels that take the maximum and the middle value.
   typedef enum logic [2:0] {
      SEC_RG = 3'd0,
      SEC_GR = 3'd1,
      SEC_GB = 3'd2,
      SEC_BG = 3'd3,
      SEC_BR = 3'd4,
      SEC_RB = 3'd5
   } sector_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic                               result_valid;
      logic [$clog2(BACK_STAGES+1)-1:0]   inflight;
   } back_status_type;

   function automatic rgb_type arrange(sector_type sector, logic [7:0] mx, logic [7:0] md,
                                       logic [7:0] mn);
      rgb_type rgb;
      unique case (sector)
         SEC_RG: begin
            rgb = '{red: mx, green: md, blue: mn};
         end
         SEC_GR: begin
            rgb = '{red: md, green: mx, blue: mn};
         end
         SEC_GB: begin
            rgb = '{red: mn, green: mx, blue: md};
         end
         SEC_BG: begin
            rgb = '{red: mn, green: md, blue: mx};
         end
         SEC_BR: begin
            rgb = '{red: md, green: mn, blue: mx};
         end
         SEC_RB: begin
            rgb = '{red: mx, green: mn, blue: md};
         end
         default: begin
            rgb = '{red: mx, green: md, blue: mn};
         end
      endcase
      return rgb;
   endfunction

endpackage

/* hw/rtl/hwv_fifo.sv */
// Small flip-flop queue with a count output, used between and after the pipeline parts.
module hwv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic [AW:0]      count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_rd;

   always_comb begin
      do_rd     = rd_en && (count_ff != '0);
      wr_ptr_in = wr_en ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(wr_en) - (AW+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign count   = count_ff;

endmodule

/* hw/rtl/hwv_front.sv */
// Front part: saturates the hue, finds the sector and ramp, and forms the brightness.
module hwv_front #(
   parameter int COORD_FRAC_BITS = 16,
   localparam int VAL_W = COORD_FRAC_BITS + 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [15:0]                  hue_position,
   input  logic [hwv_pkg::WHITE_W-1:0]  whiteness,
   input  logic signed [15:0]           slider_offset,
   output logic                         valid,
   output hwv_pkg::sector_type          sector,
   output logic [VAL_W-1:0]             ramp,
   output logic [VAL_W-1:0]             diff,
   output logic [hwv_pkg::WHITE_W-1:0]  white,
   output logic [hwv_pkg::BRIGHT_W-1:0] bright
);

   localparam int F  = COORD_FRAC_BITS;
   localparam int CW = (F > 16) ? F + 1 : 17;
   localparam int SW = CW + 3;
   localparam int FW = F + 1;
   localparam int RW = F + 9;

   logic [CW-1:0]                 hue_lim, hue_ext, hue_sat;
   logic [SW-1:0]                 six, six_base;
   logic [2:0]                    sec_raw;
   logic [F-1:0]                  frac;
   logic [FW-1:0]                 fall;
   logic [RW-1:0]                 ramp_rise, ramp_fall, ramp_sel;
   logic [VAL_W-1:0]              top;
   logic signed [17:0]            bright_wide;

   logic                          valid_ff, valid_in;
   hwv_pkg::sector_type           sector_ff, sector_in;
   logic [VAL_W-1:0]              ramp_ff, ramp_in;
   logic [VAL_W-1:0]              diff_ff, diff_in;
   logic [hwv_pkg::WHITE_W-1:0]   white_ff, white_in;
   logic [hwv_pkg::BRIGHT_W-1:0]  bright_ff, bright_in;

   always_comb begin
      hue_lim     = (CW'(1) << F) - CW'(1);
      hue_ext     = CW'(hue_position);
      hue_sat     = (hue_ext > hue_lim) ? hue_lim : hue_ext;
      six         = (SW'(hue_sat) << 2) + (SW'(hue_sat) << 1);
      sec_raw     = 3'(six >> F);
      six_base    = SW'(sec_raw) << F;
      frac        = F'(six - six_base);
      fall        = (FW'(1) << F) - FW'(frac);
      ramp_rise   = (RW'(frac) << 8) - RW'(frac);
      ramp_fall   = (RW'(fall) << 8) - RW'(fall);
      ramp_sel    = sec_raw[0] ? ramp_fall : ramp_rise;
      top         = VAL_W'(hwv_pkg::CHAN_FULL) << F;
      bright_wide = 18'sd32768 - 18'(slider_offset);

      valid_in  = accept;
      sector_in = hwv_pkg::sector_type'(sec_raw);
      ramp_in   = VAL_W'(ramp_sel);
      diff_in   = top - VAL_W'(ramp_sel);
      white_in  = whiteness;
      bright_in = bright_wide[hwv_pkg::BRIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      ramp_ff   <= ramp_in;
      diff_ff   <= diff_in;
      white_ff  <= white_in;
      bright_ff <= bright_in;
   end

   assign valid  = valid_ff;
   assign sector = sector_ff;
   assign ramp   = ramp_ff;
   assign diff   = diff_ff;
   assign white  = white_ff;
   assign bright = bright_ff;

endmodule

/* hw/rtl/hwv_back.sv */
// Back part: three pipeline stages of multiplies, clamps and channel arrangement.
module hwv_back #(
   parameter int COORD_FRAC_BITS = 16,
   localparam int VAL_W = COORD_FRAC_BITS + 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         issue,
   input  hwv_pkg::sector_type          sector,
   input  logic [VAL_W-1:0]             ramp,
   input  logic [VAL_W-1:0]             diff,
   input  logic [hwv_pkg::WHITE_W-1:0]  white,
   input  logic [hwv_pkg::BRIGHT_W-1:0] bright,
   output hwv_pkg::back_status_type     status,
   output hwv_pkg::rgb_type             rgb
);

   localparam int F    = COORD_FRAC_BITS;
   localparam int SH   = 16 + F;
   localparam int P1_W = VAL_W + hwv_pkg::WHITE_W;
   localparam int W255 = hwv_pkg::WHITE_W + 8;
   localparam int MX_W = hwv_pkg::BRIGHT_W + 8;
   localparam int MN_W = W255 + hwv_pkg::BRIGHT_W;
   localparam int PQ_W = P1_W - F;
   localparam int PW   = ((PQ_W > VAL_W) ? PQ_W : VAL_W) + 1;
   localparam int MD_W = PW + hwv_pkg::BRIGHT_W;
   localparam int IF_W = $clog2(hwv_pkg::BACK_STAGES + 1);

   logic                          valid1_ff, valid1_in;
   hwv_pkg::sector_type           sector1_ff, sector1_in;
   logic [VAL_W-1:0]              ramp1_ff, ramp1_in;
   logic [P1_W-1:0]               prod1_ff, prod1_in;
   logic [W255-1:0]               w255_1_ff, w255_1_in;
   logic [hwv_pkg::BRIGHT_W-1:0]  bright1_ff, bright1_in;

   logic                          valid2_ff, valid2_in;
   hwv_pkg::sector_type           sector2_ff, sector2_in;
   logic [PW-1:0]                 pre2_ff, pre2_in;
   logic [MN_W-1:0]               mnp2_ff, mnp2_in;
   logic [7:0]                    mx2_ff, mx2_in;
   logic [hwv_pkg::BRIGHT_W-1:0]  bright2_ff, bright2_in;

   logic                          valid3_ff, valid3_in;
   hwv_pkg::rgb_type              rgb3_ff, rgb3_in;

   logic [MX_W-1:0]               mx_wide;
   logic [MD_W-1:0]               mdp, md_sh;
   logic [MN_W-1:0]               mn_sh;
   logic [7:0]                    md_val, mn_val;

   always_comb begin
      valid1_in  = issue;
      sector1_in = sector;
      ramp1_in   = ramp;
      prod1_in   = P1_W'(diff) * P1_W'(white);
      w255_1_in  = (W255'(white) << 8) - W255'(white);
      bright1_in = bright;

      mx_wide    = (MX_W'(bright1_ff) << 8) - MX_W'(bright1_ff);
      valid2_in  = valid1_ff;
      sector2_in = sector1_ff;
      pre2_in    = PW'(prod1_ff >> F) + PW'(ramp1_ff);
      mnp2_in    = MN_W'(w255_1_ff) * MN_W'(bright1_ff);
      mx2_in     = mx_wide[MX_W-1] ? hwv_pkg::CHAN_FULL : mx_wide[MX_W-2:16];
      bright2_in = bright1_ff;

      mdp        = MD_W'(pre2_ff) * MD_W'(bright2_ff);
      md_sh      = mdp >> SH;
      mn_sh      = mnp2_ff >> SH;
      md_val     = (md_sh > MD_W'(hwv_pkg::CHAN_FULL)) ? hwv_pkg::CHAN_FULL : md_sh[7:0];
      mn_val     = (mn_sh > MN_W'(hwv_pkg::CHAN_FULL)) ? hwv_pkg::CHAN_FULL : mn_sh[7:0];
      valid3_in  = valid2_ff;
      rgb3_in    = hwv_pkg::arrange(sector2_ff, mx2_ff, md_val, mn_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   always_ff @(posedge clock) begin
      sector1_ff <= sector1_in;
      ramp1_ff   <= ramp1_in;
      prod1_ff   <= prod1_in;
      w255_1_ff  <= w255_1_in;
      bright1_ff <= bright1_in;
      sector2_ff <= sector2_in;
      pre2_ff    <= pre2_in;
      mnp2_ff    <= mnp2_in;
      mx2_ff     <= mx2_in;
      bright2_ff <= bright2_in;
      rgb3_ff    <= rgb3_in;
   end

   always_comb begin
      status.result_valid = valid3_ff;
      status.inflight     = IF_W'(valid1_ff) + IF_W'(valid2_ff) + IF_W'(valid3_ff);
   end

   assign rgb = rgb3_ff;

endmodule

/* hw/rtl/hue_whiteness_value_to_rgb.sv */
// Top level of the hue, whiteness and brightness to RGB converter.
// Input side: a queue write port. A transaction carries a hue position, a whiteness
// and a signed brightness slider offset, and is taken at a clock edge with push high
// and full low. Output side: a queue read port. While empty is low the oldest
// red, green and blue result is on the rsp_ ports; pop with empty low takes it.
// Every input transaction yields exactly one result transaction, in order.
// On the way to the output, the accepting edge loads the front register, then the
// middle queue, three back pipeline stages and the output queue each register the
// result in turn. Throughput is one transaction per clock while the output queue
// has room and full stays low, set by the fully pipelined back stages that hold one
// multiplier each.
// The front and back are coupled only by a four-entry queue; the back issues only
// when the eight-entry output queue has room for everything already in flight, so
// when the receiver stops popping the block keeps accepting until both queues fill,
// then raises full, and nothing is dropped.
// Synchronous reset empties both queues and the pipeline; no setup is needed.
`include "hue_whiteness_value_to_rgb_assert.svh"

module hue_whiteness_value_to_rgb #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [15:0]                  req_hue_position,
   input  logic [hwv_pkg::WHITE_W-1:0]  req_whiteness,
   input  logic signed [15:0]           req_slider_offset,
   output logic                         empty,
   input  logic                         pop,
   output logic [7:0]                   rsp_red,
   output logic [7:0]                   rsp_green,
   output logic [7:0]                   rsp_blue
);

   localparam int VAL_W  = COORD_FRAC_BITS + 8;
   localparam int MID_W  = 3 + 2 * VAL_W + hwv_pkg::WHITE_W + hwv_pkg::BRIGHT_W;
   localparam int MID_AW = $clog2(hwv_pkg::MID_DEPTH);
   localparam int OUT_AW = $clog2(hwv_pkg::OUT_DEPTH);
   localparam int RGB_W  = $bits(hwv_pkg::rgb_type);

   logic                          accept;
   logic                          front_valid;
   hwv_pkg::sector_type           front_sector;
   logic [VAL_W-1:0]              front_ramp, front_diff;
   logic [hwv_pkg::WHITE_W-1:0]   front_white;
   logic [hwv_pkg::BRIGHT_W-1:0]  front_bright;

   logic [MID_W-1:0]              mid_wr, mid_rd;
   logic                          mid_empty;
   logic [MID_AW:0]               mid_count;
   logic                          issue;

   hwv_pkg::back_status_type      back_status;
   hwv_pkg::rgb_type              back_rgb, out_rgb;
   logic [RGB_W-1:0]              out_rd;
   logic [OUT_AW:0]               out_count;
   logic [OUT_AW+1:0]             credit_used;
   logic                          out_take;

   assign accept = push && !full;
   assign full   = (MID_AW'(0) + (MID_AW+1)'(mid_count) + (MID_AW+1)'(front_valid))
                   >= (MID_AW+1)'(hwv_pkg::MID_DEPTH);

   hwv_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .hue_position  (req_hue_position),
      .whiteness     (req_whiteness),
      .slider_offset (req_slider_offset),
      .valid         (front_valid),
      .sector        (front_sector),
      .ramp          (front_ramp),
      .diff          (front_diff),
      .white         (front_white),
      .bright        (front_bright)
   );

   assign mid_wr = {front_sector, front_ramp, front_diff, front_white, front_bright};

   hwv_fifo #(
      .WIDTH(MID_W),
      .DEPTH(hwv_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (mid_wr),
      .rd_en   (issue),
      .rd_data (mid_rd),
      .empty   (mid_empty),
      .count   (mid_count)
   );

   assign credit_used = (OUT_AW+2)'(out_count) + (OUT_AW+2)'(back_status.inflight);
   assign issue       = !mid_empty && (credit_used < (OUT_AW+2)'(hwv_pkg::OUT_DEPTH));

   hwv_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .sector (hwv_pkg::sector_type'(mid_rd[MID_W-1 -: 3])),
      .ramp   (mid_rd[MID_W-4 -: VAL_W]),
      .diff   (mid_rd[MID_W-4-VAL_W -: VAL_W]),
      .white  (mid_rd[hwv_pkg::WHITE_W+hwv_pkg::BRIGHT_W-1 -: hwv_pkg::WHITE_W]),
      .bright (mid_rd[hwv_pkg::BRIGHT_W-1:0]),
      .status (back_status),
      .rgb    (back_rgb)
   );

   assign out_take = pop && !empty;

   hwv_fifo #(
      .WIDTH(RGB_W),
      .DEPTH(hwv_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_status.result_valid),
      .wr_data (back_rgb),
      .rd_en   (out_take),
      .rd_data (out_rd),
      .empty   (empty),
      .count   (out_count)
   );

   assign out_rgb   = hwv_pkg::rgb_type'(out_rd);
   assign rsp_red   = out_rgb.red;
   assign rsp_green = out_rgb.green;
   assign rsp_blue  = out_rgb.blue;

   `HWV_ASSERT(a_mid_has_room, clock, reset, !front_valid || !mid_count[MID_AW])
   `HWV_ASSERT(a_out_credit_bound, clock, reset, credit_used <= (OUT_AW+2)'(hwv_pkg::OUT_DEPTH))
   `HWV_ASSERT_NEXT(a_accept_reaches_front, clock, reset, push && !full, front_valid)

endmodule

/* bench/tb_hue_whiteness_value_to_rgb.sv */
// Self-checking testbench for the hue, whiteness and brightness to RGB converter.
`timescale 1ns / 100ps

module tb_hue_whiteness_value_to_rgb;

   localparam int COORD_FRAC_BITS = 16;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PRINT_LIMIT     = 40;
   localparam int IDLE_PERCENT    = 17;
   localparam int WHITE_W         = hwv_pkg::WHITE_W;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   logic [15:0]        req_hue_position;
   logic [WHITE_W-1:0] req_whiteness;
   logic signed [15:0] req_slider_offset;
   logic               empty;
   logic               pop;
   logic [7:0]         rsp_red;
   logic [7:0]         rsp_green;
   logic [7:0]         rsp_blue;

   hwv_pkg::rgb_type pending_rgb[$];
   int               mismatch_count;
   int               cycle_count;
   int               hold_cycles;
   bit               no_gaps;

   hue_whiteness_value_to_rgb #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_hue_position(req_hue_position),
      .req_whiteness(req_whiteness),
      .req_slider_offset(req_slider_offset),
      .empty(empty),
      .pop(pop),
      .rsp_red(rsp_red),
      .rsp_green(rsp_green),
      .rsp_blue(rsp_blue)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] clamp_channel(logic [63:0] value);
      return (value > 64'd255) ? 8'd255 : value[7:0];
   endfunction

   function automatic hwv_pkg::rgb_type predict_rgb(logic [15:0] hue,
                                                    logic [WHITE_W-1:0] white,
                                                    logic signed [15:0] offset);
      logic [63:0]         unit_q;
      logic [63:0]         hue_q;
      logic [63:0]         bright;
      logic [63:0]         scaled;
      logic [63:0]         sector_idx;
      logic [63:0]         frac;
      logic [63:0]         ramp;
      logic [63:0]         mid_pre;
      logic [7:0]          chan[3];
      logic [7:0]          c_max;
      logic [7:0]          c_mid;
      logic [7:0]          c_min;
      int                  max_ch;
      int                  mid_ch;
      hwv_pkg::sector_type sector;
      hwv_pkg::rgb_type    rgb;
      unit_q = 64'd1 << COORD_FRAC_BITS;
      hue_q = (64'(hue) > unit_q - 64'd1) ? unit_q - 64'd1 : 64'(hue);
      bright = 64'(32768 - int'(offset));
      scaled = 64'd6 * hue_q;
      sector_idx = scaled >> COORD_FRAC_BITS;
      if (sector_idx > 64'd5) begin
         sector_idx = 64'd5;
      end
      frac = scaled - sector_idx * unit_q;
      ramp = sector_idx[0] ? 64'd255 * (unit_q - frac) : 64'd255 * frac;
      mid_pre = ((64'd255 * unit_q - ramp) * 64'(white) + ramp * unit_q) >> COORD_FRAC_BITS;
      c_max = clamp_channel((64'd255 * bright) >> 16);
      c_mid = clamp_channel((mid_pre * bright) >> (16 + COORD_FRAC_BITS));
      c_min = clamp_channel((64'd255 * 64'(white) * bright) >> (16 + COORD_FRAC_BITS));
      sector = hwv_pkg::sector_type'(sector_idx[2:0]);
      unique case (sector)
         hwv_pkg::SEC_RG: begin
            max_ch = 0;
            mid_ch = 1;
         end
         hwv_pkg::SEC_GR: begin
            max_ch = 1;
            mid_ch = 0;
         end
         hwv_pkg::SEC_GB: begin
            max_ch = 1;
            mid_ch = 2;
         end
         hwv_pkg::SEC_BG: begin
            max_ch = 2;
            mid_ch = 1;
         end
         hwv_pkg::SEC_BR: begin
            max_ch = 2;
            mid_ch = 0;
         end
         default: begin
            max_ch = 0;
            mid_ch = 2;
         end
      endcase
      chan[max_ch] = c_max;
      chan[mid_ch] = c_mid;
      chan[3 - max_ch - mid_ch] = c_min;
      rgb.red = chan[0];
      rgb.green = chan[1];
      rgb.blue = chan[2];
      return rgb;
   endfunction

   function automatic bit idle_roll();
      return !no_gaps && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // Accepted inputs are predicted and accepted results are checked at the same edge.
   always @(posedge clock) begin
      hwv_pkg::rgb_type want;
      if (!reset && push && !full) begin
         pending_rgb.push_back(predict_rgb(req_hue_position, req_whiteness,
                                           req_slider_offset));
      end
      if (!reset && pop && !empty) begin
         if (pending_rgb.size() == 0) begin
            report_mismatch("result with no pending transaction", 0, 0);
         end else begin
            want = pending_rgb.pop_front();
            if (rsp_red !== want.red) begin
               report_mismatch("red", rsp_red, want.red);
            end
            if (rsp_green !== want.green) begin
               report_mismatch("green", rsp_green, want.green);
            end
            if (rsp_blue !== want.blue) begin
               report_mismatch("blue", rsp_blue, want.blue);
            end
         end
      end
   end

   // The receiver counts down a requested hold-off itself.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         pop <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         pop <= !idle_roll();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_item(logic [15:0] hue, logic [WHITE_W-1:0] white,
                            logic signed [15:0] offset);
      @(negedge clock);
      while (idle_roll()) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_hue_position <= hue;
      req_whiteness <= white;
      req_slider_offset <= offset;
      do begin
         @(posedge clock);
      end while (full);
   endtask

   task automatic send_random(bit wide);
      logic [WHITE_W-1:0] white;
      logic signed [15:0] offset;
      if (wide) begin
         white = WHITE_W'($urandom_range(2 ** WHITE_W - 1));
         offset = 16'($urandom);
      end else begin
         white = WHITE_W'($urandom_range(65536));
         offset = 16'(int'($urandom_range(61440)) - 30720);
      end
      send_item(16'($urandom_range(65535)), white, offset);
   endtask

   task automatic test_corners();
      send_item(16'd0, 17'd0, 16'sd0);
      send_item(16'd65535, 17'd65536, 16'sd0);
      send_item(16'd0, 17'd65536, -16'sd30720);
      send_item(16'd65535, 17'd0, 16'sd30720);
      send_item(16'd32768, 17'd32768, -16'sd32768);
      send_item(16'd12000, 17'd131071, -16'sd32768);
      send_item(16'd50000, 17'd131071, 16'sd32767);
      send_item(16'd40000, 17'd100000, 16'sd0);
      send_item(16'd20000, 17'd65535, 16'sd32767);
      send_item(16'd60000, 17'd1, -16'sd1);
      send_item(16'd5000, 17'd70000, 16'sd1);
      send_item(16'd27000, 17'd20000, -16'sd30720);
   endtask

   task automatic test_sector_edges();
      int first_hue;
      for (int k = 1; k < 6; k++) begin
         first_hue = (k * 65536 + 5) / 6;
         send_item(16'(first_hue - 1), WHITE_W'($urandom_range(65536)), 16'sd0);
         send_item(16'(first_hue), WHITE_W'($urandom_range(65536)), -16'sd12800);
      end
   endtask

   task automatic test_random_wheel(int count);
      repeat (count) begin
         send_random($urandom_range(99) < 15);
      end
   endtask

   task automatic test_steady_stream(int count);
      no_gaps = 1'b1;
      repeat (count) begin
         send_random(1'b0);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_output_backpressure(int count);
      hold_cycles = 80;
      no_gaps = 1'b1;
      repeat (count) begin
         send_random(1'b0);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_wide_range(int count);
      repeat (count) begin
         send_random(1'b1);
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_hue_position = '0;
      req_whiteness = '0;
      req_slider_offset = '0;
      mismatch_count = 0;
      cycle_count = 0;
      hold_cycles = 0;
      no_gaps = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corners();
      test_sector_edges();
      test_random_wheel(500);
      test_steady_stream(150);
      test_output_backpressure(60);
      test_wide_range(140);

      @(negedge clock);
      push <= 1'b0;
      while (pending_rgb.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/hwv_pkg.sv
hw/rtl/hwv_fifo.sv
hw/rtl/hwv_front.sv
hw/rtl/hwv_back.sv
hw/rtl/hue_whiteness_value_to_rgb.sv
bench/tb_hue_whiteness_value_to_rgb.sv
